// ===== rtl/power_iteration_eigen_core_assert.svh =====
// Assertion macros for the power iteration core checkers.
`ifndef POWER_ITERATION_EIGEN_CORE_ASSERT_SVH
`define POWER_ITERATION_EIGEN_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define PIE_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("power iteration core: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define PIE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("power iteration core: next-cycle check failed");

`endif

// ===== rtl/pie_pkg.sv =====
package pie_pkg;

  localparam int MAX_SIZE_DEF      = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int RESULT_LIMIT      = 32;

  localparam logic [5:0]  SIZE_RST   = 6'd32;
  localparam logic [15:0] MAXIT_RST  = 16'd10000;
  localparam logic [30:0] TOL_RST    = 31'd1;

  typedef enum logic [1:0] {
    CMD_WR_MAT = 2'd0,
    CMD_WR_VEC = 2'd1,
    CMD_START  = 2'd2,
    CMD_NONE   = 2'd3
  } pie_cmd_e;

  typedef enum logic [1:0] {
    CFG_SIZE  = 2'd0,
    CFG_MAXIT = 2'd1,
    CFG_TOL   = 2'd2,
    CFG_NONE  = 2'd3
  } pie_cfg_e;

  // Operand selection of the shared multiply-accumulate unit
  typedef enum logic [1:0] {
    MODE_MAT = 2'd0,
    MODE_SQ  = 2'd1,
    MODE_DOT = 2'd2
  } pie_mode_e;

  // Per-cycle control broadcast to every vector cell
  typedef struct packed {
    logic        ld_en;
    logic [4:0]  ld_row;
    logic [31:0] ld_val;
    logic        b_shift;
    logic        b_tail_new;
    logic [31:0] b_new;
    logic        y_shift;
    logic        y_tail_new;
    logic [31:0] y_new;
  } pie_cell_ctrl_t;

endpackage

// ===== rtl/power_iteration_eigen_core.sv =====
// Load transactions (matrix or vector entry) are accepted back to back while the core is idle.
// A start transaction runs passes through the single multiply-accumulate unit, the bit-serial divider and square root.
// Results leave one per cycle after the last pass while out_stall_i is low, n results per run.
// Reset (asynchronous, active low) clears control and configuration; matrix and
// vector storage keep no reset value and need no clearing pass.
module power_iteration_eigen_core import pie_pkg::*; #(
  parameter int MAX_SIZE      = MAX_SIZE_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [4:0]  row_i,
  input  logic [4:0]  column_i,
  input  logic [31:0] element_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] eigen_value_o,
  output logic [4:0]  vector_index_o,
  output logic [31:0] vector_value_o,
  output logic [15:0] iterations_used_o,
  output logic        converged_o,
  output logic        zero_norm_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i
);

  localparam int IW    = $clog2(MAX_SIZE);
  localparam int AW    = $clog2(MAX_SIZE * MAX_SIZE);
  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int LIM   = (MAX_SIZE < RESULT_LIMIT) ? MAX_SIZE : RESULT_LIMIT;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LOOP = 9'b000000010,
    S_MV1  = 9'b000000100,
    S_SQ   = 9'b000001000,
    S_SQRT = 9'b000010000,
    S_NORM = 9'b000100000,
    S_MV2  = 9'b001000000,
    S_DOT  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_e;

  state_e         state_q, state_d;
  logic [5:0]     size_q;
  logic [15:0]    maxit_q, pass_q, pass_d;
  logic [30:0]    tol_q;
  logic [IW-1:0]  i_q, i_d, j_q, j_d, n_m1;
  logic           done_q, done_d, started_q, started_d;
  logic           conv_q, conv_d, zero_q, zero_d;
  logic [31:0]    eig_q, eig_d, norm_q, norm_d;
  logic           in_acc, out_acc, mv, iss, phase_end;
  pie_mode_e      mode;
  pie_cell_ctrl_t ctrl;

  logic [31:0]    mat_mem [DEPTH];
  logic [31:0]    mat_q;
  logic [AW-1:0]  waddr, raddr;
  logic           mem_we;

  logic [31:0]    b_cells [MAX_SIZE];
  logic [31:0]    y_cells [MAX_SIZE];

  logic           mac_busy, mac_push;
  logic [63:0]    mac_acc;
  logic [31:0]    mac_scaled;
  logic           sq_start, sq_done, dv_start, dv_done;
  logic [31:0]    sq_root, y_mag;
  logic [30:0]    dv_quo;
  logic [31:0]    next_val;
  logic signed [32:0] diff, adiff;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Clamp the configured size to the supported range
  always_comb begin
    int sz;
    sz = (size_q == 6'd0) ? 1 : int'(size_q);
    if (sz > LIM) begin
      sz = LIM;
    end
    n_m1 = IW'(sz - 1);
  end

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SIZE_RST;
      maxit_q <= MAXIT_RST;
      tol_q   <= TOL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (pie_cfg_e'(cfg_index_i))
        CFG_SIZE:  size_q  <= cfg_data_i[5:0];
        CFG_MAXIT: maxit_q <= cfg_data_i[15:0];
        CFG_TOL:   tol_q   <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // Matrix store: one write port for loads, one registered read port for the MAC
  assign mem_we = in_acc && (pie_cmd_e'(command_i) == CMD_WR_MAT) &&
                  (int'(row_i) < MAX_SIZE) && (int'(column_i) < MAX_SIZE);
  assign waddr  = AW'(int'(row_i) * MAX_SIZE + int'(column_i));
  assign raddr  = AW'(int'(i_q) * MAX_SIZE + int'(j_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mat_mem[waddr] <= element_value_i;
    end
    mat_q <= mat_mem[raddr];
  end

  // Issue control of the multiply-accumulate sweeps
  assign mv        = (state_q == S_MV1) || (state_q == S_MV2);
  assign iss       = (mv || (state_q == S_SQ) || (state_q == S_DOT)) && !done_q;
  assign phase_end = done_q && !mac_busy;

  always_comb begin
    unique case (state_q)
      S_MV1, S_MV2: mode = MODE_MAT;
      S_SQ:         mode = MODE_SQ;
      default:      mode = MODE_DOT;
    endcase
  end

  pie_mac #(.FRACTION_BITS(FRACTION_BITS)) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .iss_i    (iss),
    .first_i  (j_q == '0),
    .last_i   (j_q == n_m1),
    .mode_i   (mode),
    .mat_i    (mat_q),
    .b_i      (b_cells[0]),
    .y_i      (y_cells[0]),
    .busy_o   (mac_busy),
    .push_o   (mac_push),
    .acc_o    (mac_acc),
    .scaled_o (mac_scaled)
  );

  pie_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (mac_acc),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign y_mag = y_cells[0][31] ? (32'd0 - y_cells[0]) : y_cells[0];

  pie_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .mag_i   (y_mag),
    .den_i   (norm_q),
    .done_o  (dv_done),
    .quo_o   (dv_quo)
  );

  assign next_val = y_cells[0][31] ? (32'd0 - {1'b0, dv_quo}) : {1'b0, dv_quo};
  assign sq_start = (state_q == S_SQRT) && !started_q;
  assign dv_start = (state_q == S_NORM) && !started_q;

  // Cell ring control
  always_comb begin
    ctrl            = '0;
    ctrl.ld_en      = in_acc && (pie_cmd_e'(command_i) == CMD_WR_VEC);
    ctrl.ld_row     = row_i;
    ctrl.ld_val     = element_value_i;
    ctrl.b_shift    = (iss && (mv || (state_q == S_DOT))) ||
                      ((state_q == S_NORM) && dv_done) ||
                      ((state_q == S_OUT) && out_acc);
    ctrl.b_tail_new = (state_q == S_NORM);
    ctrl.b_new      = next_val;
    ctrl.y_shift    = (iss && ((state_q == S_SQ) || (state_q == S_DOT))) ||
                      ((state_q == S_NORM) && dv_done) || (mv && mac_push);
    ctrl.y_tail_new = mv;
    ctrl.y_new      = mac_scaled;
  end

  for (genvar k = 0; k < MAX_SIZE; k++) begin : g_cell
    logic [31:0] b_nbr, y_nbr;
    if (k == MAX_SIZE - 1) begin : g_end
      assign b_nbr = b_cells[0];
      assign y_nbr = y_cells[0];
    end else begin : g_mid
      assign b_nbr = b_cells[k+1];
      assign y_nbr = y_cells[k+1];
    end
    pie_cell #(.IDX(k), .IW(IW)) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .last_idx_i (n_m1),
      .b_nbr_i    (b_nbr),
      .y_nbr_i    (y_nbr),
      .b_head_i   (b_cells[0]),
      .y_head_i   (y_cells[0]),
      .b_o        (b_cells[k]),
      .y_o        (y_cells[k])
    );
  end

  // Eigenvalue change against the tolerance
  always_comb begin
    diff  = $signed({mac_scaled[31], mac_scaled}) - $signed({eig_q[31], eig_q});
    adiff = diff[32] ? -diff : diff;
  end

  // Run sequencer
  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    done_d    = done_q;
    started_d = started_q;
    pass_d    = pass_q;
    conv_d    = conv_q;
    zero_d    = zero_q;
    eig_d     = eig_q;
    norm_d    = norm_q;

    if (iss) begin
      if (j_q == n_m1) begin
        j_d = '0;
        if (!mv || (i_q == n_m1)) begin
          done_d = 1'b1;
          i_d    = '0;
        end else begin
          i_d = i_q + IW'(1);
        end
      end else begin
        j_d = j_q + IW'(1);
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (pie_cmd_e'(command_i) == CMD_START)) begin
          eig_d   = '0;
          pass_d  = '0;
          conv_d  = 1'b0;
          zero_d  = 1'b0;
          i_d     = '0;
          j_d     = '0;
          state_d = S_LOOP;
        end
      end
      S_LOOP: begin
        if (pass_q < maxit_q) begin
          pass_d  = pass_q + 16'd1;
          state_d = S_MV1;
        end else begin
          state_d = S_OUT;
        end
      end
      S_MV1: begin
        if (phase_end) begin
          done_d  = 1'b0;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        if (phase_end) begin
          done_d  = 1'b0;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        if (!started_q) begin
          started_d = 1'b1;
        end else if (sq_done) begin
          started_d = 1'b0;
          if (sq_root == '0) begin
            zero_d  = 1'b1;
            state_d = S_OUT;
          end else begin
            norm_d  = sq_root;
            state_d = S_NORM;
          end
        end
      end
      S_NORM: begin
        if (!started_q) begin
          started_d = 1'b1;
        end else if (dv_done) begin
          started_d = 1'b0;
          if (j_q == n_m1) begin
            j_d     = '0;
            state_d = S_MV2;
          end else begin
            j_d = j_q + IW'(1);
          end
        end
      end
      S_MV2: begin
        if (phase_end) begin
          done_d  = 1'b0;
          state_d = S_DOT;
        end
      end
      S_DOT: begin
        if (phase_end) begin
          done_d = 1'b0;
          eig_d  = mac_scaled;
          if (adiff < $signed({2'b00, tol_q})) begin
            conv_d  = 1'b1;
            state_d = S_OUT;
          end else begin
            state_d = S_LOOP;
          end
        end
      end
      S_OUT: begin
        if (out_acc) begin
          if (j_q == n_m1) begin
            j_d     = '0;
            state_d = S_IDLE;
          end else begin
            j_d = j_q + IW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      i_q       <= '0;
      j_q       <= '0;
      done_q    <= 1'b0;
      started_q <= 1'b0;
      pass_q    <= '0;
      conv_q    <= 1'b0;
      zero_q    <= 1'b0;
      eig_q     <= '0;
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      j_q       <= j_d;
      done_q    <= done_d;
      started_q <= started_d;
      pass_q    <= pass_d;
      conv_q    <= conv_d;
      zero_q    <= zero_d;
      eig_q     <= eig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    norm_q <= norm_d;
  end

  // Result port, read from the head of the vector ring
  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = (state_q == S_OUT);
  assign eigen_value_o     = eig_q;
  assign vector_index_o    = 5'(j_q);
  assign vector_value_o    = b_cells[0];
  assign iterations_used_o = pass_q;
  assign converged_o       = conv_q;
  assign zero_norm_o       = zero_q;
  assign last_o            = (j_q == n_m1);

endmodule

// ===== rtl/pie_cell.sv =====
module pie_cell import pie_pkg::*; #(
  parameter int IDX = 0,
  parameter int IW  = 5
) (
  input  logic                  clk_i,
  input  pie_cell_ctrl_t        ctrl_i,
  input  logic [IW-1:0]         last_idx_i,
  input  logic [31:0]           b_nbr_i,
  input  logic [31:0]           y_nbr_i,
  input  logic [31:0]           b_head_i,
  input  logic [31:0]           y_head_i,
  output logic [31:0]           b_o,
  output logic [31:0]           y_o
);

  logic [31:0] b_q, b_d, y_q, y_d;
  logic        active, tail;

  // Cells past the last index in use do not shift, but still take loads by index
  always_comb begin
    active = (IDX <= int'(last_idx_i));
    tail   = (IDX == int'(last_idx_i));
  end

  // Load by index, or shift toward cell zero with the tail fed from head or new data
  always_comb begin
    b_d = b_q;
    if (ctrl_i.ld_en && (int'(ctrl_i.ld_row) == IDX)) begin
      b_d = ctrl_i.ld_val;
    end else if (ctrl_i.b_shift && active) begin
      if (tail) begin
        b_d = ctrl_i.b_tail_new ? ctrl_i.b_new : b_head_i;
      end else begin
        b_d = b_nbr_i;
      end
    end
  end

  always_comb begin
    y_d = y_q;
    if (ctrl_i.y_shift && active) begin
      if (tail) begin
        y_d = ctrl_i.y_tail_new ? ctrl_i.y_new : y_head_i;
      end else begin
        y_d = y_nbr_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    b_q <= b_d;
    y_q <= y_d;
  end

  assign b_o = b_q;
  assign y_o = y_q;

endmodule

// ===== rtl/pie_mac.sv =====
module pie_mac import pie_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        iss_i,
  input  logic        first_i,
  input  logic        last_i,
  input  pie_mode_e   mode_i,
  input  logic [31:0] mat_i,
  input  logic [31:0] b_i,
  input  logic [31:0] y_i,
  output logic        busy_o,
  output logic        push_o,
  output logic [63:0] acc_o,
  output logic [31:0] scaled_o
);

  localparam logic signed [64:0] SMAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SMIN = -65'sh0_7FFF_FFFF_FFFF_FFFF;

  logic               v1_q, f1_q, l1_q, v2_q, f2_q, l2_q, push_q;
  logic [31:0]        b1_q, y1_q, opa, opb;
  logic signed [63:0] prod_q;
  logic [63:0]        acc_q, acc_d, base;
  logic signed [64:0] ssum;
  logic [64:0]        usum;
  logic signed [63:0] shr;

  // Stage one: capture vector operands beside the registered matrix read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      push_q <= 1'b0;
    end else begin
      v1_q   <= iss_i;
      v2_q   <= v1_q;
      push_q <= v2_q && l2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q <= first_i;
    l1_q <= last_i;
    b1_q <= b_i;
    y1_q <= y_i;
  end

  // Stage two: one signed 32x32 product
  always_comb begin
    opa = (mode_i == MODE_MAT) ? mat_i : y1_q;
    opb = (mode_i == MODE_SQ) ? y1_q : b1_q;
  end

  always_ff @(posedge clk_i) begin
    f2_q   <= f1_q;
    l2_q   <= l1_q;
    prod_q <= $signed(opa) * $signed(opb);
  end

  // Stage three: saturating accumulate, unsigned for the sum of squares
  always_comb begin
    base  = f2_q ? 64'd0 : acc_q;
    ssum  = $signed({base[63], base}) + $signed({prod_q[63], prod_q});
    usum  = {1'b0, base} + {1'b0, prod_q};
    acc_d = acc_q;
    if (mode_i == MODE_SQ) begin
      acc_d = usum[64] ? {64{1'b1}} : usum[63:0];
    end else if (ssum > SMAX) begin
      acc_d = SMAX[63:0];
    end else if (ssum < SMIN) begin
      acc_d = SMIN[63:0];
    end else begin
      acc_d = ssum[63:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      acc_q <= acc_d;
    end
  end

  // Floor shift out of the fraction and saturate to 32 bits
  always_comb begin
    shr = $signed(acc_q) >>> FRACTION_BITS;
    if (shr > 64'sh0000_0000_7FFF_FFFF) begin
      scaled_o = 32'h7FFF_FFFF;
    end else if (shr < -64'sh0000_0000_8000_0000) begin
      scaled_o = 32'h8000_0000;
    end else begin
      scaled_o = shr[31:0];
    end
  end

  assign busy_o = v1_q || v2_q || push_q;
  assign push_o = push_q;
  assign acc_o  = acc_q;

endmodule

// ===== rtl/pie_isqrt.sv =====
module pie_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, done_q, ge;
  logic [4:0]  cnt_q;
  logic [63:0] x_q;
  logic [33:0] rem_q, rem_n, trial;
  logic [31:0] root_q;

  // One result bit per cycle from the top two radicand bits
  always_comb begin
    rem_n = {rem_q[31:0], x_q[63:62]};
    trial = {root_q, 2'b01};
    ge    = (rem_n >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[61:0], 2'b00};
      rem_q  <= ge ? (rem_n - trial) : rem_n;
      root_q <= {root_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/pie_div.sv =====
module pie_div import pie_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] mag_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [30:0] quo_o
);

  localparam int W  = 32 + FRACTION_BITS;
  localparam int CW = $clog2(W + 1);

  logic          busy_q, done_q, ge;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  dq_q;
  logic [31:0]   rem_q, den_q;
  logic [32:0]   rem_sh;

  // Restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, dq_q[W-1]};
    ge     = (rem_sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= {mag_i, {FRACTION_BITS{1'b0}}};
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
      dq_q  <= {dq_q[W-2:0], ge};
    end
  end

  // Saturate the quotient to the largest positive value
  assign quo_o  = (|dq_q[W-1:31]) ? {31{1'b1}} : dq_q[30:0];
  assign done_o = done_q;

endmodule

// ===== rtl/pie_checker.sv =====
`include "power_iteration_eigen_core_assert.svh"

module pie_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [4:0]  vector_index_o,
  input logic [31:0] vector_value_o,
  input logic        converged_o,
  input logic        zero_norm_o,
  input logic        last_o
);

  // Hold off new transactions while results are out
  `PIE_ASSERT_NOW(a_busy_out, out_valid_o, in_stall_o)

  // A run ends on the tolerance test, on a zero norm or at the iteration limit, never with both flags
  `PIE_ASSERT_NOW(a_flags_excl, out_valid_o, !(converged_o && zero_norm_o))

  // Indices count up one per accepted result
  `PIE_ASSERT_NEXT(a_idx_step, out_valid_o && !out_stall_i && !last_o, out_valid_o && (vector_index_o == $past(vector_index_o) + 5'd1))

  // Drop the result stream after the final element
  `PIE_ASSERT_NEXT(a_last_ends, out_valid_o && !out_stall_i && last_o, !out_valid_o)

  // Hold a stalled result
  `PIE_ASSERT_NEXT(a_stall_hold, out_valid_o && out_stall_i, out_valid_o && $stable(vector_value_o))

endmodule

bind power_iteration_eigen_core pie_checker u_pie_checker (.*);
